FILE: sv/spo_pkg.sv
// Shared types and constants of the spiral order matrix reader.
// Used by the channel interfaces, the controller, the datapath and the top level.
package spo_pkg;

  localparam int ELEM_W    = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Request codes of the input channel.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // How the walk position moves on a read.
  typedef enum logic [2:0] {
    WK_HOLD,
    WK_INC,
    WK_DEC,
    WK_ROW_BEGIN,
    WK_ROW_END,
    WK_COL_END,
    WK_NEXT_ROW_BEGIN,
    WK_NEXT_COL_BEGIN
  } walk_op_t;

  // Which bounds form the row and column of the read address.
  typedef enum logic [1:0] {
    AD_TOP,
    AD_RIGHT,
    AD_BOTTOM,
    AD_LEFT
  } addr_sel_t;

  // Shape of a ring held in a set of bounds.
  typedef enum logic [1:0] {
    RING_EMPTY,
    RING_FULL,
    RING_ROW,
    RING_COL
  } ring_t;

  typedef struct packed {
    logic      load;
    logic      read;
    logic      err;
    walk_op_t  walk;
    addr_sel_t addr_sel;
    logic      shrink;
    logic      restart;
    logic      last;
  } spo_cmd_t;

  typedef struct packed {
    logic  full;
    logic  out_busy;
    logic  wp_inc_col_end;
    logic  wp_inc_row_end;
    logic  wp_dec_col_begin;
    logic  wp_dec_row_begin;
    logic  wp_ge_col_end;
    logic  wp_ge_row_end;
    ring_t next_ring;
    ring_t first_ring;
  } spo_stat_t;

endpackage

FILE: sv/spo_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on spo_pkg for the element width.
interface spo_in_if;
  import spo_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ELEM_W-1:0] elem_value;

  modport source (output valid, output req_type, output elem_value, input ready);
  modport sink (input valid, input req_type, input elem_value, output ready);
endinterface

interface spo_out_if;
  import spo_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] out_value;
  logic                     last;
  logic                     not_ready;

  modport source (output valid, output out_value, output last, output not_ready,
                  input ready);
  modport sink (input valid, input out_value, input last, input not_ready,
                output ready);
endinterface

FILE: sv/spo_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module spo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/spo_ctrl.sv
// Controller of the spiral order matrix reader: tracks the side of the ring
// being walked and issues commands to spo_dp. Depends on spo_pkg.
module spo_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                in_valid,
  input  logic                in_req_type,
  input  logic                out_ready,
  output logic                in_ready,
  input  spo_pkg::spo_stat_t  stat,
  output spo_pkg::spo_cmd_t   cmd
);
  import spo_pkg::*;

  typedef enum logic [2:0] {
    PH_TOP,
    PH_RIGHT,
    PH_BOTTOM,
    PH_LEFT,
    PH_ROW,
    PH_COL
  } phase_t;

  phase_t phase_r;
  phase_t phase_nxt;
  logic   accept;

  function automatic phase_t ring_phase(input ring_t ring);
    phase_t ph;
    unique case (ring)
      RING_FULL: ph = PH_TOP;
      RING_ROW:  ph = PH_ROW;
      RING_COL:  ph = PH_COL;
      RING_EMPTY: ph = PH_ROW;
      default:   ph = PH_ROW;
    endcase
    return ph;
  endfunction

  // A new request is taken whenever the result register is free or drains now,
  // but never during reset or in the cycle of a configuration write.
  assign in_ready = rst_n && !cfg_we && (!stat.out_busy || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    cmd.walk  = WK_HOLD;
    cmd.addr_sel = AD_TOP;
    phase_nxt = phase_r;
    if (cfg_we) begin
      cmd.restart = 1'b1;
      phase_nxt   = ring_phase(stat.first_ring);
    end else if (accept) begin
      if (in_req_type == REQ_LOAD) begin
        cmd.load = !stat.full;
      end else if (!stat.full) begin
        cmd.err = 1'b1;
      end else begin
        cmd.read = 1'b1;
        unique case (phase_r)
          PH_TOP: begin
            cmd.addr_sel = AD_TOP;
            if (stat.wp_inc_col_end) begin
              phase_nxt = PH_RIGHT;
              cmd.walk  = WK_ROW_BEGIN;
            end else begin
              cmd.walk = WK_INC;
            end
          end
          PH_RIGHT: begin
            cmd.addr_sel = AD_RIGHT;
            if (stat.wp_inc_row_end) begin
              phase_nxt = PH_BOTTOM;
              cmd.walk  = WK_COL_END;
            end else begin
              cmd.walk = WK_INC;
            end
          end
          PH_BOTTOM: begin
            cmd.addr_sel = AD_BOTTOM;
            if (stat.wp_dec_col_begin) begin
              phase_nxt = PH_LEFT;
              cmd.walk  = WK_ROW_END;
            end else begin
              cmd.walk = WK_DEC;
            end
          end
          PH_LEFT: begin
            cmd.addr_sel = AD_LEFT;
            if (!stat.wp_dec_row_begin) begin
              cmd.walk = WK_DEC;
            end else begin
              // The ring is closed: step inward, or finish if nothing is left.
              unique case (stat.next_ring)
                RING_EMPTY: begin
                  cmd.last    = 1'b1;
                  cmd.restart = 1'b1;
                  phase_nxt   = ring_phase(stat.first_ring);
                end
                RING_FULL: begin
                  cmd.shrink = 1'b1;
                  cmd.walk   = WK_NEXT_COL_BEGIN;
                  phase_nxt  = PH_TOP;
                end
                RING_ROW: begin
                  cmd.shrink = 1'b1;
                  cmd.walk   = WK_NEXT_COL_BEGIN;
                  phase_nxt  = PH_ROW;
                end
                RING_COL: begin
                  cmd.shrink = 1'b1;
                  cmd.walk   = WK_NEXT_ROW_BEGIN;
                  phase_nxt  = PH_COL;
                end
                default: begin
                  cmd.walk = WK_HOLD;
                end
              endcase
            end
          end
          PH_ROW: begin
            cmd.addr_sel = AD_TOP;
            if (stat.wp_ge_col_end) begin
              cmd.last    = 1'b1;
              cmd.restart = 1'b1;
              phase_nxt   = ring_phase(stat.first_ring);
            end else begin
              cmd.walk = WK_INC;
            end
          end
          PH_COL: begin
            cmd.addr_sel = AD_LEFT;
            if (stat.wp_ge_row_end) begin
              cmd.last    = 1'b1;
              cmd.restart = 1'b1;
              phase_nxt   = ring_phase(stat.first_ring);
            end else begin
              cmd.walk = WK_INC;
            end
          end
          default: begin
            phase_nxt = PH_ROW;
          end
        endcase
      end
    end
  end

  // After reset the matrix is 1 by 1, which is walked as a single row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ROW;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |=> !stat.full)
    else $error("matrix still full after the final element");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !stat.full)
    else $error("matrix still full after a configuration write");

  a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.read || cmd.err) |=> stat.out_busy)
    else $error("read request produced no pending result");

endmodule

FILE: sv/spo_dp.sv
// Datapath of the spiral order matrix reader: configuration, ring bounds,
// walk position, element store and result register. Depends on spo_pkg, spo_ram.
module spo_dp #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [spo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spo_pkg::CFG_W-1:0]            cfg_wdata,
  input  spo_pkg::spo_cmd_t                    cmd,
  input  logic [spo_pkg::ELEM_W-1:0]           elem_value,
  input  logic                                 out_ready,
  output spo_pkg::spo_stat_t                   stat,
  output logic                                 out_valid,
  output logic signed [spo_pkg::ELEM_W-1:0]    out_value,
  output logic                                 out_last,
  output logic                                 out_not_ready
);
  import spo_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WPW   = (RW > CW) ? RW : CW;
  localparam int WX    = WPW + 1;
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int TW    = ERW + ECW;
  localparam int PW    = WPW + ECW + 1;
  localparam int RX    = RW + 2;
  localparam int CX    = CW + 2;

  logic [CFG_W-1:0]      num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0]      num_cols_r, num_cols_nxt;
  logic [LCW-1:0]        load_cnt_r, load_cnt_nxt;
  logic [RW-1:0]         rb_r, rb_nxt, re_r, re_nxt;
  logic [CW-1:0]         cb_r, cb_nxt, ce_r, ce_nxt;
  logic [WPW-1:0]        wp_r, wp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_err_r, out_err_nxt;

  logic [ERW-1:0]        eff_rows, eff_rows_nxt;
  logic [ECW-1:0]        eff_cols, eff_cols_nxt;
  logic [TW-1:0]         total;
  logic                  full;
  logic [WX-1:0]         wp_x, rb_x, re_x, cb_x, ce_x;
  logic [RX-1:0]         rb2, re_rx;
  logic [CX-1:0]         cb2, ce_cx;
  logic [WPW-1:0]        row_sel, col_sel;
  logic [PW-1:0]         addr_full;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic                  wr_en;

  function automatic logic [ERW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [ERW-1:0] res;
    if (v == '0) begin
      res = ERW'(1);
    end else if (int'(v) > MAX_ROWS) begin
      res = ERW'(MAX_ROWS);
    end else begin
      res = ERW'(v);
    end
    return res;
  endfunction

  function automatic logic [ECW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [ECW-1:0] res;
    if (v == '0) begin
      res = ECW'(1);
    end else if (int'(v) > MAX_COLS) begin
      res = ECW'(MAX_COLS);
    end else begin
      res = ECW'(v);
    end
    return res;
  endfunction

  assign num_rows_nxt = (cfg_we && cfg_index == REG_NUM_ROWS) ? cfg_wdata : num_rows_r;
  assign num_cols_nxt = (cfg_we && cfg_index == REG_NUM_COLS) ? cfg_wdata : num_cols_r;

  assign eff_rows     = clamp_rows(num_rows_r);
  assign eff_cols     = clamp_cols(num_cols_r);
  assign eff_rows_nxt = clamp_rows(num_rows_nxt);
  assign eff_cols_nxt = clamp_cols(num_cols_nxt);

  assign total = TW'(eff_rows) * TW'(eff_cols);
  assign full  = (TW'(load_cnt_r) == total);

  assign wp_x = WX'(wp_r);
  assign rb_x = WX'(rb_r);
  assign re_x = WX'(re_r);
  assign cb_x = WX'(cb_r);
  assign ce_x = WX'(ce_r);

  // The next ring is empty when begin plus two passes end on either axis.
  assign rb2   = RX'(rb_r) + RX'(2);
  assign re_rx = RX'(re_r);
  assign cb2   = CX'(cb_r) + CX'(2);
  assign ce_cx = CX'(ce_r);

  always_comb begin
    stat                  = '0;
    stat.full             = full;
    stat.out_busy         = out_valid_r;
    stat.wp_inc_col_end   = (wp_x + WX'(1)) == ce_x;
    stat.wp_inc_row_end   = (wp_x + WX'(1)) == re_x;
    stat.wp_dec_col_begin = wp_x == (cb_x + WX'(1));
    stat.wp_dec_row_begin = wp_x == (rb_x + WX'(1));
    stat.wp_ge_col_end    = wp_x >= ce_x;
    stat.wp_ge_row_end    = wp_x >= re_x;
    priority if (rb2 > re_rx || cb2 > ce_cx) begin
      stat.next_ring = RING_EMPTY;
    end else if (rb2 < re_rx && cb2 < ce_cx) begin
      stat.next_ring = RING_FULL;
    end else if (rb2 == re_rx) begin
      stat.next_ring = RING_ROW;
    end else begin
      stat.next_ring = RING_COL;
    end
    priority if (eff_rows_nxt > ERW'(1) && eff_cols_nxt > ECW'(1)) begin
      stat.first_ring = RING_FULL;
    end else if (eff_rows_nxt == ERW'(1)) begin
      stat.first_ring = RING_ROW;
    end else begin
      stat.first_ring = RING_COL;
    end
  end

  // Read address: row times the row pitch plus column.
  always_comb begin
    unique case (cmd.addr_sel)
      AD_TOP: begin
        row_sel = WPW'(rb_r);
        col_sel = wp_r;
      end
      AD_RIGHT: begin
        row_sel = wp_r;
        col_sel = WPW'(ce_r);
      end
      AD_BOTTOM: begin
        row_sel = WPW'(re_r);
        col_sel = wp_r;
      end
      AD_LEFT: begin
        row_sel = wp_r;
        col_sel = WPW'(cb_r);
      end
      default: begin
        row_sel = '0;
        col_sel = '0;
      end
    endcase
  end

  assign addr_full = PW'(row_sel) * PW'(eff_cols) + PW'(col_sel);
  assign rd_addr   = addr_full[AW-1:0];
  assign wr_addr   = load_cnt_r[AW-1:0];
  assign wr_en     = cmd.load && !full;
  assign wr_data   = DATA_WIDTH'($unsigned(elem_value));

  spo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.read),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    rb_nxt       = rb_r;
    re_nxt       = re_r;
    cb_nxt       = cb_r;
    ce_nxt       = ce_r;
    wp_nxt       = wp_r;
    if (cmd.restart) begin
      load_cnt_nxt = '0;
      rb_nxt       = '0;
      cb_nxt       = '0;
      re_nxt       = RW'(eff_rows_nxt - ERW'(1));
      ce_nxt       = CW'(eff_cols_nxt - ECW'(1));
      wp_nxt       = '0;
    end else begin
      if (wr_en) begin
        load_cnt_nxt = load_cnt_r + LCW'(1);
      end
      if (cmd.shrink) begin
        rb_nxt = rb_r + RW'(1);
        re_nxt = re_r - RW'(1);
        cb_nxt = cb_r + CW'(1);
        ce_nxt = ce_r - CW'(1);
      end
      unique case (cmd.walk)
        WK_HOLD:           wp_nxt = wp_r;
        WK_INC:            wp_nxt = wp_r + WPW'(1);
        WK_DEC:            wp_nxt = wp_r - WPW'(1);
        WK_ROW_BEGIN:      wp_nxt = WPW'(rb_r);
        WK_ROW_END:        wp_nxt = WPW'(re_r);
        WK_COL_END:        wp_nxt = WPW'(ce_r);
        WK_NEXT_ROW_BEGIN: wp_nxt = WPW'(rb_r) + WPW'(1);
        WK_NEXT_COL_BEGIN: wp_nxt = WPW'(cb_r) + WPW'(1);
        default:           wp_nxt = wp_r;
      endcase
    end
  end

  // The result register holds a read result until its transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (cmd.read || cmd.err) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = cmd.last;
      out_err_nxt   = cmd.err;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= CFG_W'(1);
      num_cols_r  <= CFG_W'(1);
      load_cnt_r  <= '0;
      rb_r        <= '0;
      re_r        <= '0;
      cb_r        <= '0;
      ce_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_err_r   <= 1'b0;
    end else begin
      num_rows_r  <= num_rows_nxt;
      num_cols_r  <= num_cols_nxt;
      load_cnt_r  <= load_cnt_nxt;
      rb_r        <= rb_nxt;
      re_r        <= re_nxt;
      cb_r        <= cb_nxt;
      ce_r        <= ce_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_err_r   <= out_err_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_last      = out_last_r;
  assign out_not_ready = out_err_r;
  assign out_value     = out_err_r ? '0 : ELEM_W'(rd_data);

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (rb_r <= re_r) && (cb_r <= ce_r))
    else $error("ring bounds crossed");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    TW'(load_cnt_r) <= total)
    else $error("load count beyond matrix size");

endmodule

FILE: sv/matrix_spiral_order_reader.sv
// Top level of the spiral order matrix reader: controller, datapath and ports.
// Depends on spo_pkg, spo_if, spo_ram, spo_ctrl and spo_dp.
//
// Usage: write num_rows (index 0) and num_cols (index 1) on the cfg port while
// the block is idle; every write empties the matrix. Then send num_rows *
// num_cols load requests (req_type 0) on in_ch carrying the elements in
// row-major order; loads beyond that count are dropped. Each read request
// (req_type 1) then produces one result on out_ch, in clockwise spiral order,
// the final one with last set, after which the block expects a new matrix.
// A read before the matrix is full returns not_ready with a zero value.
// Loads produce no result. One request is taken per cycle; a read result
// shows on out_ch in the cycle after its transfer, since the element store
// read is registered. The result register parts the two channels: in_ch.ready
// is low during reset and in the cycle of a cfg write, and otherwise drops
// only while a result waits and out_ch.ready is low, so a stalled receiver
// holds the block without losing anything.
// Reset sets both sizes to 1 and empties the matrix; the store itself is not
// cleared and needs no clearing pass.
module matrix_spiral_order_reader #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spo_pkg::CFG_W-1:0]     cfg_wdata,
  spo_in_if.sink                        in_ch,
  spo_out_if.source                     out_ch
);
  import spo_pkg::*;

  spo_cmd_t  cmd;
  spo_stat_t stat;

  spo_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .out_ready   (out_ch.ready),
    .in_ready    (in_ch.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  spo_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .elem_value    (in_ch.elem_value),
    .out_ready     (out_ch.ready),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_value     (out_ch.out_value),
    .out_last      (out_ch.last),
    .out_not_ready (out_ch.not_ready)
  );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for matrix_spiral_order_reader: loads matrices of many sizes,
// reads them back in spiral order and checks every result against an in-bench predictor.
// Depends on spo_pkg, the spo_if channel interfaces and the RTL of the block.
module testbench;
  import spo_pkg::*;

  localparam int MAX_DIM  = 16;
  localparam int SETTLE   = 4;
  localparam int HOLD_LEN = 200;

  typedef enum logic [2:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT,
    SIDE_ROW,
    SIDE_COL
  } side_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
    logic              not_ready;
  } spiral_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 hold_out = 1'b0;

  spo_in_if  in_ch ();
  spo_out_if out_ch ();

  matrix_spiral_order_reader i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: the stored matrix, the walk bounds and the size registers.
  logic [ELEM_W-1:0] elem_mem [MAX_DIM*MAX_DIM];
  int                loaded;
  int                top_row, bot_row, left_col, right_col, walk_idx;
  side_t             walk_side;
  logic [CFG_W-1:0]  rows_reg, cols_reg;

  spiral_res_t spiral_due [$];
  int          counted_reqs = 0;
  int          fail_count = 0;
  int          in_idle = 0;
  int          out_stall = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("testbench: errors");
    $finish;
  end

  function automatic int rows_used();
    if (rows_reg == 0) return 1;
    return (rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg);
  endfunction

  function automatic int cols_used();
    if (cols_reg == 0) return 1;
    return (cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg);
  endfunction

  // Picks the first side of the ring inside the current bounds; 0 when nothing is left.
  function automatic bit enter_ring();
    if (top_row > bot_row || left_col > right_col) return 1'b0;
    if (top_row < bot_row && left_col < right_col) begin
      walk_side = SIDE_TOP;
      walk_idx  = left_col;
    end else if (top_row == bot_row) begin
      walk_side = SIDE_ROW;
      walk_idx  = left_col;
    end else begin
      walk_side = SIDE_COL;
      walk_idx  = top_row;
    end
    return 1'b1;
  endfunction

  function automatic void clear_matrix();
    loaded    = 0;
    top_row   = 0;
    left_col  = 0;
    bot_row   = rows_used() - 1;
    right_col = cols_used() - 1;
    void'(enter_ring());
  endfunction

  // Moves the walk one element on; returns 1 once the spiral is complete.
  function automatic bit step_walk();
    case (walk_side)
      SIDE_TOP: begin
        walk_idx++;
        if (walk_idx == right_col) begin
          walk_side = SIDE_RIGHT;
          walk_idx  = top_row;
        end
      end
      SIDE_RIGHT: begin
        walk_idx++;
        if (walk_idx == bot_row) begin
          walk_side = SIDE_BOTTOM;
          walk_idx  = right_col;
        end
      end
      SIDE_BOTTOM: begin
        walk_idx--;
        if (walk_idx == left_col) begin
          walk_side = SIDE_LEFT;
          walk_idx  = bot_row;
        end
      end
      SIDE_LEFT: begin
        walk_idx--;
        if (walk_idx == top_row) begin
          top_row++;
          left_col++;
          bot_row--;
          right_col--;
          return !enter_ring();
        end
      end
      SIDE_ROW: begin
        if (walk_idx >= right_col) return 1'b1;
        walk_idx++;
      end
      default: begin
        if (walk_idx >= bot_row) return 1'b1;
        walk_idx++;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_request(logic rt, logic [ELEM_W-1:0] v);
    spiral_res_t res;
    int          row, col, total;
    total = rows_used() * cols_used();
    if (rt == REQ_LOAD) begin
      // Loads past the full count are dropped and do not count as useful traffic.
      if (loaded < total) begin
        elem_mem[loaded] = v;
        loaded++;
        counted_reqs++;
      end
      return;
    end
    counted_reqs++;
    if (loaded < total) begin
      res.value     = '0;
      res.last      = 1'b0;
      res.not_ready = 1'b1;
      spiral_due.push_back(res);
      return;
    end
    case (walk_side)
      SIDE_TOP:    begin row = top_row;  col = walk_idx;  end
      SIDE_RIGHT:  begin row = walk_idx; col = right_col; end
      SIDE_BOTTOM: begin row = bot_row;  col = walk_idx;  end
      SIDE_LEFT:   begin row = walk_idx; col = left_col;  end
      SIDE_ROW:    begin row = top_row;  col = walk_idx;  end
      default:     begin row = walk_idx; col = left_col;  end
    endcase
    res.value     = elem_mem[row * cols_used() + col];
    res.not_ready = 1'b0;
    res.last      = step_walk();
    spiral_due.push_back(res);
    if (res.last) clear_matrix();
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly small sizes; zero and oversized values exercise the clamping.
  function automatic logic [CFG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 15) return CFG_W'($urandom_range(17, 31));
    if (roll < 20) return CFG_W'(MAX_DIM);
    return CFG_W'($urandom_range(1, 6));
  endfunction

  task automatic send_req(input logic rt, input logic [ELEM_W-1:0] v);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rt;
    in_ch.elem_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(rt, v);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (spiral_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_ROWS) rows_reg = val;
    else cols_reg = val;
    clear_matrix();
    @(posedge clk);
  endtask

  task automatic load_all();
    int total;
    total = rows_used() * cols_used();
    for (int i = 0; i < total; i++) send_req(REQ_LOAD, pick_elem());
  endtask

  task automatic read_n(input int n);
    for (int i = 0; i < n; i++) send_req(REQ_READ, '0);
  endtask

  task automatic test_one_element();
    send_req(REQ_READ, '0);
    send_req(REQ_LOAD, 32'h8000_0000);
    send_req(REQ_LOAD, 32'h7fff_ffff);
    send_req(REQ_READ, '0);
    send_req(REQ_READ, '0);
  endtask

  task automatic test_thin_shapes();
    set_size(REG_NUM_ROWS, '0);
    set_size(REG_NUM_COLS, '0);
    send_req(REQ_LOAD, '1);
    send_req(REQ_READ, '0);
    set_size(REG_NUM_ROWS, 5'd1);
    set_size(REG_NUM_COLS, 5'd4);
    for (int i = 0; i < 4; i++) send_req(REQ_LOAD, ELEM_W'(i + 1));
    read_n(4);
    set_size(REG_NUM_ROWS, 5'd3);
    set_size(REG_NUM_COLS, 5'd1);
    for (int i = 0; i < 3; i++) send_req(REQ_LOAD, ELEM_W'(32'h7fff_fff0 + i));
    read_n(3);
  endtask

  // A size write in the middle of loading empties the matrix.
  task automatic test_restart_on_write();
    set_size(REG_NUM_ROWS, 5'd2);
    set_size(REG_NUM_COLS, 5'd2);
    send_req(REQ_LOAD, 32'h1234_5678);
    send_req(REQ_LOAD, 32'hfedc_ba98);
    set_size(REG_NUM_COLS, 5'd2);
    send_req(REQ_READ, '0);
  endtask

  task automatic test_full_size();
    in_idle   = 8;
    out_stall = 8;
    set_size(REG_NUM_ROWS, 5'd31);
    set_size(REG_NUM_COLS, 5'd16);
    load_all();
    read_n(MAX_DIM * MAX_DIM);
  endtask

  // The receiver holds off while reads keep coming, so the block must stall its input.
  task automatic test_backpressure();
    in_idle   = 0;
    out_stall = 0;
    set_size(REG_NUM_ROWS, 5'd4);
    set_size(REG_NUM_COLS, 5'd4);
    load_all();
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_out <= 1'b0;
      end
      read_n(16);
    join
  endtask

  task automatic random_matrix();
    int total, cut;
    if ($urandom_range(99) < 30)
      set_size($urandom_range(1) ? REG_NUM_COLS : REG_NUM_ROWS, pick_size());
    total = rows_used() * cols_used();
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(99) < 5) send_req(REQ_READ, '0);
      send_req(REQ_LOAD, pick_elem());
    end
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 3)) send_req(REQ_LOAD, pick_elem());
    end
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(total - 1);
      read_n(cut);
      set_size(REG_NUM_ROWS, rows_reg);
      return;
    end
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(99) < 5) send_req(REQ_LOAD, pick_elem());
      send_req(REQ_READ, '0);
    end
  endtask

  task automatic test_random_traffic();
    int idle_pct  [4] = '{0, 55, 0, 8};
    int stall_pct [4] = '{0, 0, 55, 8};
    int start;
    for (int p = 0; p < 4; p++) begin
      in_idle   = idle_pct[p];
      out_stall = stall_pct[p];
      start     = counted_reqs;
      while (counted_reqs - start < 75) random_matrix();
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_out && ($urandom_range(99) >= out_stall);
    end
  end

  always @(posedge clk) begin
    spiral_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (spiral_due.size() == 0) begin
        $error("unexpected result: out_value %0h last %0b not_ready %0b",
               out_ch.out_value, out_ch.last, out_ch.not_ready);
        fail_count++;
      end else begin
        want = spiral_due.pop_front();
        if (out_ch.out_value !== want.value) begin
          $error("out_value: expected %0h, got %0h", want.value, out_ch.out_value);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          fail_count++;
        end
        if (out_ch.not_ready !== want.not_ready) begin
          $error("not_ready: expected %0b, got %0b", want.not_ready, out_ch.not_ready);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_NUM_ROWS;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_LOAD;
    in_ch.elem_value = '0;
    rows_reg         = 5'd1;
    cols_reg         = 5'd1;
    clear_matrix();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_one_element();
    test_thin_shapes();
    test_restart_on_write();
    test_full_size();
    test_backpressure();
    test_random_traffic();

    settle();
    if (fail_count == 0 && spiral_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/spo_pkg.sv
sv/spo_if.sv
sv/spo_ram.sv
sv/spo_ctrl.sv
sv/spo_dp.sv
sv/matrix_spiral_order_reader.sv
dv/testbench.sv
